// File: src/dmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types and constants for the duplicate message filter.
// ----------------------------------------------------------------------------
package dmf_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int ADDR_W = 32;
    localparam int SEQ_W  = 16;
    localparam int TIME_W = 32;
    localparam int HOLD_W = 16;

    localparam logic [HOLD_W-1:0] HOLD_TIME_RST = HOLD_W'(30);

    localparam logic ACT_CHECK = 1'b0;
    localparam logic ACT_PURGE = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] expiry;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic free;
        logic expired;
    } match_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

// File: src/dmf_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_table
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dmf_table #(
    parameter int TABLE_ENTRIES = dmf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             wen,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] waddr,
    input  dmf_pkg::entry_t                  wdata,
    input  logic                             ren,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
    output dmf_pkg::entry_t                  rdata
);
    import dmf_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/dmf_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_match
// Entry compare unit: key match, free slot and expiry test for one entry.
// ----------------------------------------------------------------------------
module dmf_match (
    input  dmf_pkg::entry_t                    entry,
    input  logic [dmf_pkg::ADDR_W-1:0]         address,
    input  logic [dmf_pkg::SEQ_W-1:0]          seq,
    input  logic [dmf_pkg::TIME_W-1:0]         now,
    output dmf_pkg::match_t                    result
);
    import dmf_pkg::*;

    always_comb
    begin
        result.hit     = entry.valid && (entry.address == address) && (entry.seq == seq);
        result.free    = !entry.valid;
        result.expired = entry.valid && (entry.expiry < now);
    end

endmodule

// File: src/dmf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_ctrl
// Sequencer: clear pass, table scan, insertion and result register.
// ----------------------------------------------------------------------------
module dmf_ctrl #(
    parameter int TABLE_ENTRIES = dmf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [dmf_pkg::ADDR_W-1:0]        orig_address,
    input  logic [dmf_pkg::SEQ_W-1:0]         msg_seq,
    input  logic                              sender_is_relay_selector,
    input  logic [dmf_pkg::TIME_W-1:0]        now,
    input  logic [dmf_pkg::HOLD_W-1:0]        hold_time,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              forward,
    output logic                              set_changed,
    output logic                              table_full,
    output logic                              mem_wen,
    output logic [$clog2(TABLE_ENTRIES)-1:0]  mem_waddr,
    output dmf_pkg::entry_t                   mem_wdata,
    output logic                              mem_ren,
    output logic [$clog2(TABLE_ENTRIES)-1:0]  mem_raddr,
    input  dmf_pkg::entry_t                   mem_rdata
);
    import dmf_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pidx_reg, pidx_next;
    logic              hit_reg, hit_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              changed_reg, changed_next;
    logic              fwd_reg, fwd_next;
    logic              full_reg, full_next;
    logic              out_valid_reg, out_valid_next;

    logic              action_reg, action_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic              relay_reg, relay_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] expiry_reg, expiry_next;
    logic              out_fwd_reg, out_fwd_next;
    logic              out_chg_reg, out_chg_next;
    logic              out_full_reg, out_full_next;

    logic [TIME_W:0]   exp_sum;
    match_t            cmp;

    dmf_match u_match (
        .entry   (mem_rdata),
        .address (addr_reg),
        .seq     (seq_reg),
        .now     (now_reg),
        .result  (cmp)
    );

    assign exp_sum = {1'b0, now} + {{(TIME_W + 1 - HOLD_W){1'b0}}, hold_time};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            changed_reg    <= 1'b0;
            fwd_reg        <= 1'b0;
            full_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            changed_reg    <= changed_next;
            fwd_reg        <= fwd_next;
            full_reg       <= full_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        free_idx_reg <= free_idx_next;
        action_reg   <= action_next;
        addr_reg     <= addr_next;
        seq_reg      <= seq_next;
        relay_reg    <= relay_next;
        now_reg      <= now_next;
        expiry_reg   <= expiry_next;
        out_fwd_reg  <= out_fwd_next;
        out_chg_reg  <= out_chg_next;
        out_full_reg <= out_full_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        changed_next    = changed_reg;
        fwd_next        = fwd_reg;
        full_next       = full_reg;
        action_next     = action_reg;
        addr_next       = addr_reg;
        seq_next        = seq_reg;
        relay_next      = relay_reg;
        now_next        = now_reg;
        expiry_next     = expiry_reg;
        out_fwd_next    = out_fwd_reg;
        out_chg_next    = out_chg_reg;
        out_full_next   = out_full_reg;
        out_valid_next  = out_valid_reg && out_stall;

        mem_wen   = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_ren   = 1'b0;
        mem_raddr = '0;
        in_stall  = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wen   = 1'b1;
                mem_waddr = cnt_reg[IDX_W-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    action_next     = action;
                    addr_next       = orig_address;
                    seq_next        = msg_seq;
                    relay_next      = sender_is_relay_selector;
                    now_next        = now;
                    expiry_next     = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
                    cnt_next        = '0;
                    pend_next       = 1'b0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    changed_next    = 1'b0;
                    fwd_next        = 1'b0;
                    full_next       = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (cnt_reg < CNT_END)
                begin
                    mem_ren   = 1'b1;
                    mem_raddr = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (action_reg == ACT_PURGE)
                    begin
                        if (cmp.expired)
                        begin
                            mem_wen         = 1'b1;
                            mem_waddr       = pidx_reg;
                            mem_wdata       = mem_rdata;
                            mem_wdata.valid = 1'b0;
                            changed_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        if (cmp.hit)
                        begin
                            hit_next = 1'b1;
                        end
                        if (cmp.free && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = pidx_reg;
                        end
                    end
                end

                if ((cnt_reg == CNT_END) && !pend_reg)
                begin
                    if ((action_reg == ACT_CHECK) && !hit_reg && relay_reg)
                    begin
                        fwd_next = 1'b1;
                        if (free_found_reg)
                        begin
                            mem_wen           = 1'b1;
                            mem_waddr         = free_idx_reg;
                            mem_wdata.valid   = 1'b1;
                            mem_wdata.address = addr_reg;
                            mem_wdata.seq     = seq_reg;
                            mem_wdata.expiry  = expiry_reg;
                            changed_next      = 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_fwd_next   = fwd_reg;
                    out_chg_next   = changed_reg;
                    out_full_next  = full_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign forward     = out_fwd_reg;
    assign set_changed = out_chg_reg;
    assign table_full  = out_full_reg;

    // scan counter stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_END)
        else $error("scan counter past table end");

    // write-back never targets the entry being read
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wen && mem_ren) |-> (mem_waddr != mem_raddr))
        else $error("read and write collide on one entry");

    // an overflow never comes with an insertion, and always with a forward
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_full_reg || (out_fwd_reg && !out_chg_reg)))
        else $error("inconsistent overflow result");

    // no read in flight once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("pending read while idle");

    // a scan ends in the response state with the read pipe drained
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && state_next == ST_RESP) |-> (cnt_reg == CNT_END))
        else $error("scan ended early");

endmodule

// File: src/duplicate_message_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_message_filter
// Duplicate filter for flooded routing messages with expiring entries.
// ----------------------------------------------------------------------------
// Each request walks the whole table through one compare unit, one entry per
// cycle from a single-port-read memory, then hands its result to the output
// register. The input is stalled while a request is in the scan. After reset
// a clearing pass empties every table entry before the first request is
// taken; hold_time writes are taken at any time. When a new message from a
// relay selector finds no free entry, it is forwarded, nothing is stored and
// table_full is flagged.
module duplicate_message_filter #(
    parameter int TABLE_ENTRIES = dmf_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [dmf_pkg::HOLD_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [dmf_pkg::ADDR_W-1:0]  orig_address,
    input  logic [dmf_pkg::SEQ_W-1:0]   msg_seq,
    input  logic                        sender_is_relay_selector,
    input  logic [dmf_pkg::TIME_W-1:0]  now,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        forward,
    output logic                        set_changed,
    output logic                        table_full
);
    import dmf_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [HOLD_W-1:0] hold_time_reg;

    logic             mem_wen;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_ren;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg <= HOLD_TIME_RST;
        end
        else if (cfg_wr_en)
        begin
            hold_time_reg <= cfg_wr_data;
        end
    end

    dmf_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .ren   (mem_ren),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dmf_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .in_valid                 (in_valid),
        .in_stall                 (in_stall),
        .action                   (action),
        .orig_address             (orig_address),
        .msg_seq                  (msg_seq),
        .sender_is_relay_selector (sender_is_relay_selector),
        .now                      (now),
        .hold_time                (hold_time_reg),
        .out_valid                (out_valid),
        .out_stall                (out_stall),
        .forward                  (forward),
        .set_changed              (set_changed),
        .table_full               (table_full),
        .mem_wen                  (mem_wen),
        .mem_waddr                (mem_waddr),
        .mem_wdata                (mem_wdata),
        .mem_ren                  (mem_ren),
        .mem_raddr                (mem_raddr),
        .mem_rdata                (mem_rdata)
    );

endmodule
